// ===== hw/rtl/mbrot_pkg.sv =====
// Shared constants and types for the Mandelbrot escape-time block.
package mbrot_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int C_W           = 32;
    localparam int CNT_W         = 16;
    localparam int SHADE_W       = 16;

    localparam logic [CNT_W-1:0] MAX_ITER_RESET = 16'd10;

    localparam int S_TDATA_W = 2 * C_W;
    localparam int M_TDATA_W = CNT_W + SHADE_W;

    typedef struct packed {
        logic             done;
        logic             in_set;
        logic [CNT_W-1:0] count;
    } iter_res_t;

endpackage

// ===== hw/rtl/mbrot_div.sv =====
// Restoring divider, one quotient bit per cycle, for the Q0.16 shade.
module mbrot_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [mbrot_pkg::CNT_W-1:0]         dividend,
    input  logic [mbrot_pkg::CNT_W-1:0]         divisor,
    output logic                                done,
    output logic [mbrot_pkg::SHADE_W-1:0]       quotient
);

    localparam int CW = mbrot_pkg::CNT_W;
    localparam int QW = mbrot_pkg::SHADE_W;
    localparam logic [$clog2(QW)-1:0] LAST_STEP = $clog2(QW)'(QW - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [$clog2(QW)-1:0]  cnt_reg;
    logic [CW-1:0]          rem_reg;
    logic [CW-1:0]          div_reg;
    logic [QW-1:0]          quo_reg;

    logic [CW:0]            rem_sh;
    logic                   ge;
    logic [CW:0]            rem_diff;

    always_comb begin
        rem_sh   = {rem_reg, 1'b0};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_diff = rem_sh - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            div_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/mbrot_iter.sv =====
// Iteration engine: z = z*z + c on one shared signed multiplier with escape test.
module mbrot_iter #(
    parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [mbrot_pkg::C_W-1:0]       c_real,
    input  logic [mbrot_pkg::C_W-1:0]       c_imag,
    input  logic [mbrot_pkg::CNT_W-1:0]     cap,
    output mbrot_pkg::iter_res_t            res
);

    localparam int CW = mbrot_pkg::C_W;
    localparam int NW = mbrot_pkg::CNT_W;
    localparam int ZW = (FRAC_BITS + 4 > CW + 1) ? FRAC_BITS + 4 : CW + 1;
    localparam int PW = 2 * ZW;
    localparam logic [PW-1:0] ESC_LIMIT = {{(PW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    typedef enum logic [4:0] {
        IT_IDLE = 5'b00001,
        IT_RR   = 5'b00010,
        IT_II   = 5'b00100,
        IT_CHK  = 5'b01000,
        IT_UPD  = 5'b10000
    } it_state_t;

    it_state_t              state_reg, state_next;

    logic signed [ZW-1:0]   re_reg, im_reg, cr_reg, ci_reg;
    logic [NW-1:0]          n_reg;
    logic [NW-1:0]          cap_reg;
    logic signed [PW-1:0]   rr_reg, ii_reg, ri_reg;

    logic signed [ZW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod;
    logic [PW-1:0]          mag_sum;
    logic                   escaped;
    logic                   stop;
    logic signed [PW-1:0]   diff;
    logic signed [PW-1:0]   two_ri;
    logic [PW-1:0]          re_sh, im_sh;
    logic signed [ZW-1:0]   re_new, im_new;
    logic signed [ZW-1:0]   cr_ext, ci_ext;

    always_comb begin
        mul_a = re_reg;
        mul_b = re_reg;
        case (state_reg)
            IT_II:   begin mul_a = im_reg; mul_b = im_reg; end
            IT_CHK:  begin mul_a = re_reg; mul_b = im_reg; end
            default: begin mul_a = re_reg; mul_b = re_reg; end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb begin
        mag_sum = rr_reg + ii_reg;
        escaped = mag_sum > ESC_LIMIT;
        stop    = (n_reg >= cap_reg) || escaped;
        diff    = rr_reg - ii_reg;
        two_ri  = ri_reg <<< 1;
        re_sh   = PW'(diff >>> FRAC_BITS);
        im_sh   = PW'(two_ri >>> FRAC_BITS);
        re_new  = re_sh[ZW-1:0] + cr_reg;
        im_new  = im_sh[ZW-1:0] + ci_reg;
        cr_ext  = {{(ZW-CW){c_real[CW-1]}}, c_real};
        ci_ext  = {{(ZW-CW){c_imag[CW-1]}}, c_imag};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            IT_IDLE: if (start) state_next = IT_RR;
            IT_RR:   state_next = IT_II;
            IT_II:   state_next = IT_CHK;
            IT_CHK:  state_next = stop ? IT_IDLE : IT_UPD;
            IT_UPD:  state_next = IT_RR;
            default: state_next = IT_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            IT_IDLE: begin
                if (start) begin
                    re_reg  <= cr_ext;
                    im_reg  <= ci_ext;
                    cr_reg  <= cr_ext;
                    ci_reg  <= ci_ext;
                    n_reg   <= NW'(1);
                    cap_reg <= cap;
                end
            end
            IT_RR:  rr_reg <= prod;
            IT_II:  ii_reg <= prod;
            IT_CHK: ri_reg <= prod;
            IT_UPD: begin
                re_reg <= re_new;
                im_reg <= im_new;
                n_reg  <= n_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign res.done   = (state_reg == IT_CHK) && stop;
    assign res.in_set = n_reg >= cap_reg;
    assign res.count  = n_reg;

endmodule

// ===== hw/rtl/mbrot_top.sv =====
// Mandelbrot escape-time top: stream ports, cap register, sequencing, result register.
// Each iteration runs the states RR, II and CHK, then UPD when it goes on; the result is then
// loaded into the output register, after the shade divide when the point escapes. A new
// point is taken only in T_IDLE, once the last result has left T_HOLD; the shared
// multiplier takes 3 products per iteration.
// Reset (aresetn low, synchronous) empties the output register, idles all sequencers, sets cap 10.
module mandelbrot_escape_time_top #(
    parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mbrot_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mbrot_pkg::S_TDATA_W-1:0]     s_tdata,  // c_real, c_imag
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mbrot_pkg::M_TDATA_W-1:0]     m_tdata,  // iteration_count, shade
    output logic                                m_tuser   // in_set
);

    localparam int CW = mbrot_pkg::C_W;
    localparam int NW = mbrot_pkg::CNT_W;
    localparam int QW = mbrot_pkg::SHADE_W;

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_ITER = 4'b0010,
        T_DIV  = 4'b0100,
        T_HOLD = 4'b1000
    } top_state_t;

    top_state_t             state_reg, state_next;
    logic [NW-1:0]          max_iter_reg;
    logic [NW-1:0]          cap;
    logic                   s_accept;
    logic                   out_free;

    mbrot_pkg::iter_res_t   iter_res;
    logic                   div_start;
    logic                   div_done;
    logic [QW-1:0]          div_quo;

    logic [NW-1:0]          count_res_reg;
    logic                   in_set_res_reg;
    logic [QW-1:0]          shade_res_reg;

    logic                   m_tvalid_reg;
    logic [NW-1:0]          m_count_reg;
    logic [QW-1:0]          m_shade_reg;
    logic                   m_in_set_reg;

    assign cap       = (max_iter_reg == '0) ? NW'(1) : max_iter_reg;
    assign s_tready  = state_reg == T_IDLE;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign div_start = (state_reg == T_ITER) && iter_res.done && !iter_res.in_set;

    mbrot_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .c_real  (s_tdata[CW-1:0]),
        .c_imag  (s_tdata[2*CW-1:CW]),
        .cap     (cap),
        .res     (iter_res)
    );

    mbrot_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (iter_res.count),
        .divisor  (cap),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:  if (s_accept) state_next = T_ITER;
            T_ITER:  if (iter_res.done) state_next = iter_res.in_set ? T_HOLD : T_DIV;
            T_DIV:   if (div_done) state_next = T_HOLD;
            T_HOLD:  if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            max_iter_reg <= mbrot_pkg::MAX_ITER_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                max_iter_reg <= cfg_wr_data;
            end
            if (state_reg == T_HOLD && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == T_ITER && iter_res.done) begin
            count_res_reg  <= iter_res.count;
            in_set_res_reg <= iter_res.in_set;
            shade_res_reg  <= '0;
        end
        if (state_reg == T_DIV && div_done) begin
            shade_res_reg <= div_quo;
        end
        if (state_reg == T_HOLD && out_free) begin
            m_count_reg  <= count_res_reg;
            m_in_set_reg <= in_set_res_reg;
            m_shade_reg  <= shade_res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_shade_reg, m_count_reg};
    assign m_tuser  = m_in_set_reg;

    a_in_set_shade_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[NW+QW-1:NW] == '0)
        else $error("shade not zero for in-set point");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[NW-1:0] != '0)
        else $error("zero iteration count");

    a_in_set_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[NW-1:0] == cap)
        else $error("in-set result with count below cap");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready while a point is in progress");

endmodule

// ===== verif/mandelbrot_escape_time_checker.sv =====
// Escape-time checker: watches both streams, predicts each pixel result and compares it.
module mandelbrot_escape_time_checker #(
    parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mbrot_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [mbrot_pkg::S_TDATA_W-1:0]     s_tdata,  // c_real, c_imag
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [mbrot_pkg::M_TDATA_W-1:0]     m_tdata,  // iteration_count, shade
    input  logic                                m_tuser,  // in_set
    output int                                  pending,
    output int                                  failures,
    output int                                  checked,
    output int                                  in_set_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mbrot_pkg::CNT_W-1:0]   iteration_count;
        logic                          in_set;
        logic [mbrot_pkg::SHADE_W-1:0] shade;
    } pixel_t;

    logic [mbrot_pkg::CNT_W-1:0] max_iter;
    pixel_t                      pixel_q[$];

    function automatic pixel_t predict_pixel(logic [31:0] re_in, logic [31:0] im_in,
                                             logic [mbrot_pkg::CNT_W-1:0] cap_in);
        logic signed [63:0]  cr, ci, zr, zi;
        logic signed [127:0] wr, wi, lim;
        int unsigned         cap, n;
        pixel_t              res;
        cr  = signed'(re_in);
        ci  = signed'(im_in);
        lim = 128'sd4 <<< (2 * FRAC_BITS);
        cap = (cap_in == 0) ? 1 : cap_in;
        zr  = cr;
        zi  = ci;
        wr  = zr;
        wi  = zi;
        n   = 1;
        while (n < cap && wr * wr + wi * wi <= lim) begin
            zr = 64'((wr * wr - wi * wi) >>> FRAC_BITS) + cr;
            zi = 64'(((wr * wi) <<< 1) >>> FRAC_BITS) + ci;
            wr = zr;
            wi = zi;
            n++;
        end
        res.iteration_count = n[15:0];
        res.in_set          = (n == cap);
        res.shade           = res.in_set ? '0 : 16'((n << 16) / cap);
        return res;
    endfunction

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        int     delta;
        if (!aresetn) begin
            max_iter    <= mbrot_pkg::MAX_ITER_RESET;
            pending     <= 0;
            failures    = 0;
            checked     = 0;
            in_set_seen = 0;
            pixel_q.delete();
        end else begin
            delta = 0;
            if (cfg_wr_en)
                max_iter <= cfg_wr_data;
            if (s_tvalid && s_tready) begin
                pixel_q.push_back(predict_pixel(s_tdata[31:0], s_tdata[63:32], max_iter));
                delta++;
            end
            if (m_tvalid && m_tready) begin
                got.iteration_count = m_tdata[15:0];
                got.shade           = m_tdata[31:16];
                got.in_set          = m_tuser;
                delta--;
                if (pixel_q.size() == 0) begin
                    $error("unexpected result transaction: iteration_count %0d", got.iteration_count);
                    failures++;
                end else begin
                    want = pixel_q.pop_front();
                    checked++;
                    if (got.in_set)
                        in_set_seen++;
                    if (got.iteration_count !== want.iteration_count) begin
                        $error("iteration_count: expected %0d, got %0d",
                               want.iteration_count, got.iteration_count);
                        failures++;
                    end
                    if (got.in_set !== want.in_set) begin
                        $error("in_set: expected %0d, got %0d", want.in_set, got.in_set);
                        failures++;
                    end
                    if (got.shade !== want.shade) begin
                        $error("shade: expected %0d, got %0d", want.shade, got.shade);
                        failures++;
                    end
                end
            end
            pending <= pending + delta;
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Testbench top: clock, reset, point and cap stimulus, ready stalls and the final verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = mbrot_pkg::FRAC_BITS_DEF;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_ITEMS  = 200;

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [mbrot_pkg::CNT_W-1:0]       cfg_wr_data = '0;
    logic                              s_tvalid    = 1'b0;
    logic                              s_tready;
    logic [mbrot_pkg::S_TDATA_W-1:0]   s_tdata     = '0;
    logic                              m_tvalid;
    logic                              m_tready    = 1'b0;
    logic [mbrot_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                              m_tuser;

    int pending, failures, checked, in_set_seen;
    int tx_idle   = 16;
    int rx_idle   = 57;
    int cur_cap   = mbrot_pkg::MAX_ITER_RESET;
    int cycles    = 0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    mandelbrot_escape_time_top #(.FRAC_BITS(FRAC_BITS)) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    mandelbrot_escape_time_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .pending     (pending),
        .failures    (failures),
        .checked     (checked),
        .in_set_seen (in_set_seen)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] fx(real v);
        return 32'($rtoi(v * (2.0 ** FRAC_BITS)));
    endfunction

    function automatic logic [63:0] random_point();
        logic [31:0] re, im;
        if ($urandom_range(99) < 20) begin
            re = $urandom;
            im = $urandom;
        end else begin
            re = $urandom_range(32'h3000_0000) - 32'h2400_0000;
            im = $urandom_range(32'h3000_0000) - 32'h1800_0000;
        end
        return {im, re};
    endfunction

    task automatic send_point(logic [31:0] re, logic [31:0] im);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic write_cap(logic [mbrot_pkg::CNT_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending > 0)
            @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_cap = value;
    endtask

    // receiver: random ready, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    initial begin
        logic [63:0]                 pt;
        logic [mbrot_pkg::CNT_W-1:0] cap_plan[6];
        cap_plan = '{16'd5, 16'd64, 16'd1, 16'd0, 16'd150, 16'd12};
        cap_plan[3] = $urandom_range(2, 40);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset cap of 10
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(fx(-2.0), 32'h0000_0000);
        send_point(fx(2.0), 32'h0000_0000);
        send_point(32'h0000_0000, fx(2.0));
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h7fff_ffff);
        send_point(32'h7fff_ffff, 32'h8000_0000);
        send_point(fx(0.25), 32'h0000_0000);
        send_point(fx(0.26), 32'h0000_0000);
        send_point(fx(-1.0), 32'h0000_0000);
        send_point(32'h0000_0001, 32'hffff_ffff);
        send_point(fx(-0.75), fx(0.1));

        write_cap(16'd0);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000);

        write_cap(16'd1);
        send_point(fx(3.0), 32'h0000_0000);
        send_point(32'h0000_0000, 32'h0000_0000);

        write_cap(16'd2);
        send_point(fx(2.0), 32'h0000_0000);
        send_point(fx(1.0), fx(1.0));
        send_point(fx(2.5), 32'h0000_0000);

        write_cap(16'hffff);
        send_point(fx(3.0), fx(3.0));
        send_point(fx(0.26), 32'h0000_0000);
        send_point(32'h0000_0000, 32'h0000_0000);

        for (int p = 0; p < 6; p++) begin
            tx_idle = (p < 2) ? 16 : (p < 4) ? 57 : 0;
            rx_idle = (p < 2) ? 57 : (p < 4) ? 16 : 0;
            write_cap(cap_plan[p]);
            if (p == 0)
                hold_req <= 1'b1;
            repeat (PHASE_ITEMS) begin
                pt = random_point();
                send_point(pt[31:0], pt[63:32]);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending > 0)
            @(posedge aclk);
        repeat (4 * cur_cap + 64) @(posedge aclk);

        $display("Checked %0d escape-time results, %0d of them in the set,", checked, in_set_seen);
        $display("over caps from 0 to 65535 with stalls and a long hold-off on the result side.");
        if (failures == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
